/* rtl/rat_pkg.sv */
// Package for the region adjacency table: shared widths, opcodes and
// colour codes, and the default parameter values. No dependencies.
`default_nettype none

package rat_pkg;

	localparam int LABEL_W    = 10;
	localparam int OPCODE_W   = 2;
	localparam int COLOR_W    = 2;
	localparam int NUM_COLORS = 3;
	localparam int OUT_SLOTS  = 4;

	localparam int DEF_MAX_REGIONS     = 1024;
	localparam int DEF_SLOTS_PER_COLOR = 4;

	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

	localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd3;

endpackage

`default_nettype wire

/* rtl/rat_req_if.sv */
// Request channel of the region adjacency table: valid/ready and one item.
// Depends on rat_pkg for the field widths.
`default_nettype none

interface rat_req_if;
	import rat_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [LABEL_W-1:0]  label_a;
	logic [COLOR_W-1:0]  color_a;
	logic [LABEL_W-1:0]  label_b;
	logic [COLOR_W-1:0]  color_b;

	modport source (output valid, opcode, label_a, color_a, label_b, color_b, input ready);
	modport sink (input valid, opcode, label_a, color_a, label_b, color_b, output ready);

endinterface

`default_nettype wire

/* rtl/rat_rsp_if.sv */
// Response channel of the region adjacency table: valid/ready and one result.
// Depends on rat_pkg for the field widths.
`default_nettype none

interface rat_rsp_if;
	import rat_pkg::*;

	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] slot_zero;
	logic [LABEL_W-1:0] slot_one;
	logic [LABEL_W-1:0] slot_two;
	logic [LABEL_W-1:0] slot_three;
	logic               overflow_first;
	logic               overflow_second;

	modport source (output valid, slot_zero, slot_one, slot_two, slot_three,
		overflow_first, overflow_second, input ready);
	modport sink (input valid, slot_zero, slot_one, slot_two, slot_three,
		overflow_first, overflow_second, output ready);

endinterface

`default_nettype wire

/* rtl/rat_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No package dependency.
`default_nettype none

module rat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/rat_slot_scan.sv */
// Slot scan for one colour set of one region: finds the label or the first
// empty slot and reports a miss when neither exists. Uses rat_pkg widths.
`default_nettype none

module rat_slot_scan import rat_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS_PER_COLOR
) (
	input  wire logic [SLOTS*LABEL_W-1:0] row,
	input  wire logic [LABEL_W-1:0]       label,
	output      logic [SLOTS*LABEL_W-1:0] new_row,
	output      logic                     miss
);

	always_comb begin
		logic done;
		done    = 1'b0;
		new_row = row;
		for (int i = 0; i < SLOTS; i++) begin
			if (!done) begin
				if (row[i*LABEL_W +: LABEL_W] == label) begin
					done = 1'b1;
				end else if (row[i*LABEL_W +: LABEL_W] == '0) begin
					new_row[i*LABEL_W +: LABEL_W] = label;
					done = 1'b1;
				end
			end
		end
		miss = !done;
	end

endmodule

`default_nettype wire

/* rtl/region_adjacency_table.sv */
// Region adjacency table top level: sequencer, neighbour store and overflow
// flag memories. Depends on rat_pkg, rat_req_if, rat_rsp_if, rat_ram and
// rat_slot_scan.
//
//   Port    Dir   Beat contents
//   ------  ----  ------------------------------------------------------
//   req     in    opcode, label_a, color_a, label_b, color_b
//   rsp     out   slot_zero..slot_three, overflow_first, overflow_second
//
// A mark goes from acceptance through a read and a write back for each side,
// then the result state; a read does side a only, and an unused opcode goes
// straight to the result state. A clear writes one row of the neighbour store
// per cycle; the same sweep runs after reset, during which req.ready stays
// low. The single write port of each memory and the registered read data
// set this order. The block takes a new beat while a finished result still
// waits on rsp; if the result register is still full when the next result is
// ready, the sequencer waits for it to drain.
`default_nettype none

module region_adjacency_table import rat_pkg::*; #(
	parameter int MAX_REGIONS     = DEF_MAX_REGIONS,
	parameter int SLOTS_PER_COLOR = DEF_SLOTS_PER_COLOR
) (
	input wire logic clk,
	input wire logic arst_n,
	rat_req_if.sink  req,
	rat_rsp_if.source rsp
);

	localparam int ROWS     = MAX_REGIONS * NUM_COLORS;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int IDX_W    = $clog2(MAX_REGIONS);
	localparam int ROW_BITS = SLOTS_PER_COLOR * LABEL_W;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_UPA  = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_UPB  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]      state_q;
	logic [ROW_W-1:0] clr_q;
	logic            clr_op_q;

	// The accepted item.
	logic [OPCODE_W-1:0] op_q;
	logic [LABEL_W-1:0]  la_q;
	logic [COLOR_W-1:0]  ca_q;
	logic [LABEL_W-1:0]  lb_q;
	logic [COLOR_W-1:0]  cb_q;

	// Results gathered while the item runs.
	logic [ROW_BITS-1:0] slots_q;
	logic                flag_a_q;
	logic                flag_b_q;

	// Result register.
	logic               out_valid_q;
	logic [LABEL_W-1:0] out_slot_q [OUT_SLOTS];
	logic               out_ovf_a_q;
	logic               out_ovf_b_q;

	// Side currently being worked on: side a updates label_a's region with
	// label_b, side b the other way round. A read uses the side a path.
	logic               side_b;
	logic [LABEL_W-1:0] region;
	logic [COLOR_W-1:0] color;
	logic [LABEL_W-1:0] ins_label;
	logic               region_ok;
	logic               color_ok;
	logic [IDX_W-1:0]   idx;
	logic [COLOR_W-1:0] col_idx;
	logic [ROW_W-1:0]   row_addr;
	logic               upd;
	logic               in_upd_state;
	logic               clr_last;

	logic                st_we;
	logic [ROW_W-1:0]    st_waddr;
	logic [ROW_BITS-1:0] st_wdata;
	logic [ROW_BITS-1:0] st_rdata;
	logic                fl_we;
	logic [IDX_W-1:0]    fl_waddr;
	logic                fl_wdata;
	logic                fl_rdata;

	logic [ROW_BITS-1:0] new_row;
	logic                miss;
	logic                flag_now;
	logic                out_load;
	logic [LABEL_W-1:0]  res_slot [OUT_SLOTS];
	logic                res_ovf_a;
	logic                res_ovf_b;

	always_comb begin
		side_b    = (state_q == S_RDB) || (state_q == S_UPB);
		region    = side_b ? lb_q : la_q;
		color     = side_b ? ca_q : ((op_q == OP_READ) ? ca_q : cb_q);
		ins_label = side_b ? la_q : lb_q;
		region_ok = 32'(region) < MAX_REGIONS;
		color_ok  = color != COLOR_NONE;
		idx       = IDX_W'(region);
		col_idx   = color_ok ? color : '0;
		// Row of the store is region * 3 + colour.
		row_addr  = (ROW_W'(idx) << 1) + ROW_W'(idx) + ROW_W'(col_idx);
		in_upd_state = (state_q == S_UPA) || (state_q == S_UPB);
		// Nothing is recorded between pixels of the same colour class.
		upd       = (op_q == OP_MARK) && (ca_q != cb_q) && region_ok && color_ok;
		clr_last  = clr_q == ROW_W'(ROWS - 1);
	end

	rat_slot_scan #(
		.SLOTS (SLOTS_PER_COLOR)
	) u_scan (
		.row     (st_rdata),
		.label   (ins_label),
		.new_row (new_row),
		.miss    (miss)
	);

	// Flag of the current region once this side's update has been applied.
	assign flag_now = region_ok && (fl_rdata || (upd && miss));

	always_comb begin
		if (state_q == S_CLR) begin
			st_we    = 1'b1;
			st_waddr = clr_q;
			st_wdata = '0;
			fl_we    = 32'(clr_q) < MAX_REGIONS;
			fl_waddr = IDX_W'(clr_q);
			fl_wdata = 1'b0;
		end else begin
			st_we    = in_upd_state && upd;
			st_waddr = row_addr;
			st_wdata = new_row;
			fl_we    = in_upd_state && upd && miss;
			fl_waddr = idx;
			fl_wdata = 1'b1;
		end
	end

	rat_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (row_addr),
		.rdata (st_rdata)
	);

	rat_ram #(
		.WIDTH (1),
		.DEPTH (MAX_REGIONS)
	) u_flags (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (idx),
		.rdata (fl_rdata)
	);

	// Result fields. Slots beyond the configured set read as zero.
	for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_slot
		if (j < SLOTS_PER_COLOR) begin : g_have
			assign res_slot[j] = (op_q == OP_READ) ? slots_q[j*LABEL_W +: LABEL_W] : '0;
		end else begin : g_none
			assign res_slot[j] = '0;
		end
	end

	always_comb begin
		// When both pixels belong to one region, side b saw the final flag.
		case (op_q)
			OP_MARK: res_ovf_a = (la_q == lb_q) ? flag_b_q : flag_a_q;
			OP_READ: res_ovf_a = flag_a_q;
			default: res_ovf_a = 1'b0;
		endcase
		res_ovf_b = (op_q == OP_MARK) && flag_b_q;
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			clr_op_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						unique case (req.opcode) inside
							OP_CLEAR: begin
								state_q  <= S_CLR;
								clr_q    <= '0;
								clr_op_q <= 1'b1;
							end
							OP_MARK, OP_READ: state_q <= S_RDA;
							OP_NONE: state_q <= S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= clr_op_q ? S_OUT : S_IDLE;
					end
				end
				S_RDA: state_q <= S_UPA;
				S_UPA: state_q <= (op_q == OP_MARK) ? S_RDB : S_OUT;
				S_RDB: state_q <= S_UPB;
				S_UPB: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item capture and per-side results.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= req.opcode;
			la_q <= req.label_a;
			ca_q <= req.color_a;
			lb_q <= req.label_b;
			cb_q <= req.color_b;
		end
		if (state_q == S_UPA) begin
			flag_a_q <= flag_now;
			slots_q  <= (region_ok && color_ok) ? st_rdata : '0;
		end
		if (state_q == S_UPB) begin
			flag_b_q <= flag_now;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q  <= res_slot;
			out_ovf_a_q <= res_ovf_a;
			out_ovf_b_q <= res_ovf_b;
		end
	end

	assign req.ready           = state_q == S_IDLE;
	assign rsp.valid           = out_valid_q;
	assign rsp.slot_zero       = out_slot_q[0];
	assign rsp.slot_one        = out_slot_q[1];
	assign rsp.slot_two        = out_slot_q[2];
	assign rsp.slot_three      = out_slot_q[3];
	assign rsp.overflow_first  = out_ovf_a_q;
	assign rsp.overflow_second = out_ovf_b_q;

`ifndef SYNTH
	// The store is only written by the clearing sweep or a write-back state.
	a_store_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == S_CLR || state_q == S_UPA || state_q == S_UPB))
		else $error("neighbour store written outside a write-back or clear state");

	// The sweep walks the rows one by one.
	a_sweep_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && !clr_last) |=> (state_q == S_CLR && clr_q == $past(clr_q) + 1'b1))
		else $error("clearing sweep skipped or stopped early");

	// A result appears only from the result state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result register loaded outside the result state");

	// An accepted beat always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != S_IDLE)
		else $error("accepted beat did not leave the idle state");
`endif

endmodule

`default_nettype wire

/* tb/sv/rat_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the region adjacency table testbench: beat types, colour names
// and the adjacency tracker class. Depends on rat_pkg.
package rat_tb_pkg;
	import rat_pkg::*;

	localparam int REGIONS = DEF_MAX_REGIONS;
	localparam int SLOTS   = DEF_SLOTS_PER_COLOR;

	localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd0;
	localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [LABEL_W-1:0]  label_a;
		logic [COLOR_W-1:0]  color_a;
		logic [LABEL_W-1:0]  label_b;
		logic [COLOR_W-1:0]  color_b;
	} rat_beat_t;

	typedef struct packed {
		logic [LABEL_W-1:0] slot_zero;
		logic [LABEL_W-1:0] slot_one;
		logic [LABEL_W-1:0] slot_two;
		logic [LABEL_W-1:0] slot_three;
		logic               overflow_first;
		logic               overflow_second;
	} rat_reply_t;

	// Mirrors the neighbour store and overflow flags, and queues the reply
	// that each accepted request beat should produce.
	class adjacency_tracker;
		logic [LABEL_W-1:0] neighbours [REGIONS][NUM_COLORS][SLOTS];
		bit                 overflowed [REGIONS];
		rat_reply_t         awaited_replies [$];
		int unsigned        mismatches;

		function new();
			wipe();
			mismatches = 0;
		endfunction

		function void wipe();
			foreach (neighbours[r, c, s])
				neighbours[r][c][s] = '0;
			foreach (overflowed[r])
				overflowed[r] = 1'b0;
		endfunction

		// An empty slot (zero) or a slot already holding the label ends the
		// scan; a full set with no match sets the region's overflow flag.
		function void record(int unsigned region, int unsigned colour,
			logic [LABEL_W-1:0] label);
			if (region >= REGIONS || colour >= NUM_COLORS)
				return;
			for (int s = 0; s < SLOTS; s++) begin
				if (neighbours[region][colour][s] == label)
					return;
				if (neighbours[region][colour][s] == '0) begin
					neighbours[region][colour][s] = label;
					return;
				end
			end
			overflowed[region] = 1'b1;
		endfunction

		function bit flag_of(int unsigned region);
			if (region >= REGIONS)
				return 1'b0;
			return overflowed[region];
		endfunction

		function void note_request(rat_beat_t b);
			rat_reply_t         r;
			logic [LABEL_W-1:0] shown [OUT_SLOTS];
			r = '0;
			foreach (shown[j])
				shown[j] = '0;
			case (b.opcode)
				OP_CLEAR: begin
					wipe();
				end
				OP_MARK: begin
					// The a side is updated first, which matters when both
					// pixels belong to the same region.
					if (b.color_a != b.color_b) begin
						record(32'(b.label_a), 32'(b.color_b), b.label_b);
						record(32'(b.label_b), 32'(b.color_a), b.label_a);
					end
					r.overflow_first  = flag_of(32'(b.label_a));
					r.overflow_second = flag_of(32'(b.label_b));
				end
				OP_READ: begin
					if (32'(b.label_a) < REGIONS && 32'(b.color_a) < NUM_COLORS)
						for (int j = 0; j < OUT_SLOTS && j < SLOTS; j++)
							shown[j] = neighbours[b.label_a][b.color_a][j];
					r.overflow_first = flag_of(32'(b.label_a));
				end
				default: begin
				end
			endcase
			r.slot_zero  = shown[0];
			r.slot_one   = shown[1];
			r.slot_two   = shown[2];
			r.slot_three = shown[3];
			awaited_replies.push_back(r);
		endfunction

		function int unsigned pending();
			return awaited_replies.size();
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_reply(rat_reply_t got);
			rat_reply_t want;
			if (awaited_replies.size() == 0) begin
				report("reply beat arrived with none outstanding");
				return;
			end
			want = awaited_replies.pop_front();
			compare_field("slot_zero", 32'(got.slot_zero), 32'(want.slot_zero));
			compare_field("slot_one", 32'(got.slot_one), 32'(want.slot_one));
			compare_field("slot_two", 32'(got.slot_two), 32'(want.slot_two));
			compare_field("slot_three", 32'(got.slot_three), 32'(want.slot_three));
			compare_field("overflow_first", 32'(got.overflow_first),
				32'(want.overflow_first));
			compare_field("overflow_second", 32'(got.overflow_second),
				32'(want.overflow_second));
		endtask
	endclass

endpackage

/* tb/sv/region_adjacency_table_tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for region_adjacency_table: clock, reset, request and
// reply handling. Depends on rat_pkg, rat_tb_pkg and the two channel interfaces.
module region_adjacency_table_tb;
	import rat_pkg::*;
	import rat_tb_pkg::*;

	// Number of random request beats that actually do something; marks with
	// equal colours and unused opcodes come on top of this figure, which
	// brings the random part to roughly 875 beats.
	localparam int unsigned RANDOM_ITEMS = 680;
	// Random beats at the tail of the run go through without any idling.
	localparam int unsigned QUIET_TAIL   = 120;
	// A clear is issued once per this many effective random beats.
	localparam int unsigned CLEAR_EVERY  = 150;
	// Pool of labels is redrawn this often, so that slot sets fill up.
	localparam int unsigned POOL_EVERY   = 60;

	logic clk;
	logic arst_n;

	rat_req_if req_ch ();
	rat_rsp_if rsp_ch ();

	region_adjacency_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	adjacency_tracker tracker = new();

	// Idling controls: gaps on the request side, stalls on the reply side, and the quiet stretch for both.
	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	bit quiet     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog for a hung run. The run holds about nine hundred beats, each
	// with at most a request gap and a reply stall, plus six sweeps (reset and
	// clears); the timeout below is set above the slowest correct run.
	initial begin
		#10_000_000;
		$display("region_adjacency_table_tb failed");
		$finish;
	end

	// Reply side: every beat taken at a rising edge is checked against the
	// oldest outstanding expectation. Ready drops in random bursts unless stalls
	// are off or the run is in a quiet stretch.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				tracker.check_reply('{rsp_ch.slot_zero, rsp_ch.slot_one,
					rsp_ch.slot_two, rsp_ch.slot_three,
					rsp_ch.overflow_first, rsp_ch.overflow_second});
			if (quiet) begin
				stall_left = 0;
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic rat_beat_t beat_of(logic [OPCODE_W-1:0] op,
		logic [LABEL_W-1:0] la, logic [COLOR_W-1:0] ca,
		logic [LABEL_W-1:0] lb, logic [COLOR_W-1:0] cb);
		rat_beat_t b;
		b.opcode  = op;
		b.label_a = la;
		b.color_a = ca;
		b.label_b = lb;
		b.color_b = cb;
		return b;
	endfunction

	// Most random beats are marks and reads within a small pool of labels, so
	// that slot sets fill up and overflow; the rest use the whole label range
	// or the unused opcode.
	function automatic rat_beat_t random_beat(logic [LABEL_W-1:0] base,
		int unsigned span);
		rat_beat_t   b;
		int unsigned pick;
		pick      = $urandom_range(0, 99);
		b.opcode  = (pick >= 55 && pick < 90) ? OP_READ : OP_MARK;
		b.label_a = base + LABEL_W'($urandom_range(0, span - 1));
		b.label_b = base + LABEL_W'($urandom_range(0, span - 1));
		b.color_a = COLOR_W'($urandom_range(0, 2));
		b.color_b = COLOR_W'($urandom_range(0, 2));
		if ($urandom_range(0, 19) == 0)
			b.color_a = COLOR_NONE;
		if ($urandom_range(0, 19) == 0)
			b.color_b = COLOR_NONE;
		if ($urandom_range(0, 19) == 0)
			b.label_b = '0;
		if (pick >= 90) begin
			b.label_a = LABEL_W'($urandom);
			b.label_b = LABEL_W'($urandom);
			b.color_a = COLOR_W'($urandom);
			b.color_b = COLOR_W'($urandom);
			if (pick < 94)
				b.opcode = OP_NONE;
		end
		return b;
	endfunction

	function automatic bit has_effect(rat_beat_t b);
		if (b.opcode == OP_NONE)
			return 1'b0;
		return !(b.opcode == OP_MARK && b.color_a == b.color_b);
	endfunction

	// Holds one beat on the request channel until it is taken. Valid is left
	// high so that back-to-back beats need no second assignment in one step.
	task automatic send_beat(input rat_beat_t b);
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= b.opcode;
		req_ch.label_a <= b.label_a;
		req_ch.color_a <= b.color_a;
		req_ch.label_b <= b.label_b;
		req_ch.color_b <= b.color_b;
		do
			@(posedge clk);
		while (!req_ch.ready);
		tracker.note_request(b);
	endtask

	task automatic sender_gap(input int unsigned cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic issue(input rat_beat_t b);
		if (!quiet && gaps_on && $urandom_range(0, 4) == 0)
			sender_gap($urandom_range(1, 17));
		send_beat(b);
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		rat_beat_t          b;
		int unsigned        effective;
		int unsigned        issued;
		int unsigned        pool_size;
		logic [LABEL_W-1:0] pool_base;
		bit                 held;

		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_NONE;
		req_ch.label_a <= '0;
		req_ch.color_a <= COLOR_NONE;
		req_ch.label_b <= '0;
		req_ch.color_b <= COLOR_NONE;
		arst_n         <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The block sweeps its store after reset, so the first
		// beat simply waits for ready.
		issue(beat_of(OP_READ, 10'd0, COLOR_BLACK, 10'd0, COLOR_BLACK));
		issue(beat_of(OP_MARK, 10'd1023, COLOR_BLACK, 10'd1, COLOR_GREEN));
		issue(beat_of(OP_READ, 10'd1023, COLOR_GREEN, 10'd0, COLOR_BLACK));
		// The same pair again must leave both slot sets as they are.
		issue(beat_of(OP_MARK, 10'd1, COLOR_GREEN, 10'd1023, COLOR_BLACK));
		// Equal colours record nothing.
		issue(beat_of(OP_MARK, 10'd5, COLOR_WHITE, 10'd6, COLOR_WHITE));
		// A pixel with no colour class is not recorded; its own region still records the other pixel.
		issue(beat_of(OP_MARK, 10'd7, COLOR_NONE, 10'd8, COLOR_GREEN));
		issue(beat_of(OP_READ, 10'd7, COLOR_NONE, 10'd0, COLOR_BLACK));
		// Both pixels in one region: the region becomes its own neighbour.
		issue(beat_of(OP_MARK, 10'd9, COLOR_BLACK, 10'd9, COLOR_WHITE));
		issue(beat_of(OP_READ, 10'd9, COLOR_WHITE, 10'd0, COLOR_BLACK));
		// Fill the green set of region 1023, then push it into overflow.
		issue(beat_of(OP_MARK, 10'd1023, COLOR_BLACK, 10'd2, COLOR_GREEN));
		issue(beat_of(OP_MARK, 10'd1023, COLOR_BLACK, 10'd3, COLOR_GREEN));
		issue(beat_of(OP_MARK, 10'd1023, COLOR_BLACK, 10'd4, COLOR_GREEN));
		issue(beat_of(OP_MARK, 10'd1023, COLOR_BLACK, 10'd6, COLOR_GREEN));
		// Label zero matches an empty slot, so region 1023 keeps no entry.
		issue(beat_of(OP_MARK, 10'd0, COLOR_WHITE, 10'd1023, COLOR_GREEN));
		// Label zero against a full set still raises overflow.
		issue(beat_of(OP_MARK, 10'd10, COLOR_GREEN, 10'd682, COLOR_BLACK));
		issue(beat_of(OP_MARK, 10'd10, COLOR_GREEN, 10'd341, COLOR_BLACK));
		issue(beat_of(OP_MARK, 10'd10, COLOR_GREEN, 10'd1023, COLOR_BLACK));
		issue(beat_of(OP_MARK, 10'd10, COLOR_GREEN, 10'd512, COLOR_BLACK));
		issue(beat_of(OP_MARK, 10'd10, COLOR_GREEN, 10'd0, COLOR_BLACK));
		// The unused opcode must answer with all fields zero.
		issue(beat_of(OP_NONE, 10'd1023, COLOR_NONE, 10'd1023, COLOR_NONE));
		issue(beat_of(OP_READ, 10'd1023, COLOR_GREEN, 10'd0, COLOR_BLACK));
		issue(beat_of(OP_READ, 10'd10, COLOR_BLACK, 10'd0, COLOR_BLACK));
		issue(beat_of(OP_CLEAR, 10'd0, COLOR_BLACK, 10'd0, COLOR_BLACK));
		issue(beat_of(OP_READ, 10'd1023, COLOR_GREEN, 10'd0, COLOR_BLACK));
		issue(beat_of(OP_READ, 10'd0, COLOR_GREEN, 10'd0, COLOR_BLACK));

		// Let the block run dry before the random part starts.
		sender_gap(1);
		wait_drained();

		effective = 0;
		issued    = 0;
		held      = 1'b0;
		pool_size = 8;
		pool_base = '0;
		while (effective < RANDOM_ITEMS) begin
			if (issued % POOL_EVERY == 0) begin
				pool_size = $urandom_range(3, 24);
				pool_base = LABEL_W'($urandom_range(0, 1023 - pool_size));
				gaps_on   = $urandom_range(0, 3) != 0;
				stalls_on = $urandom_range(0, 3) != 0;
			end
			quiet = effective >= RANDOM_ITEMS - QUIET_TAIL;
			if (!held && effective >= RANDOM_ITEMS / 2) begin
				// The sender holds off once until every reply is in.
				held = 1'b1;
				sender_gap(1);
				wait_drained();
			end
			if (effective % CLEAR_EVERY == CLEAR_EVERY - 1)
				b = beat_of(OP_CLEAR, LABEL_W'($urandom), COLOR_W'($urandom),
					LABEL_W'($urandom), COLOR_W'($urandom));
			else
				b = random_beat(pool_base, pool_size);
			issue(b);
			issued++;
			if (has_effect(b))
				effective++;
		end
		req_ch.valid <= 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("region_adjacency_table_tb passed");
		end else begin
			$display("region_adjacency_table_tb failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/rat_pkg.sv
rtl/rat_req_if.sv
rtl/rat_rsp_if.sv
rtl/rat_ram.sv
rtl/rat_slot_scan.sv
rtl/region_adjacency_table.sv
tb/sv/rat_tb_pkg.sv
tb/sv/region_adjacency_table_tb.sv
